// File: rtl/core/uvol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvol_pkg
// Shared types, codes and constants of the unique value ordered list.
// ----------------------------------------------------------------------------
package uvol_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int MAX_RESULTS  = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_OUT_W  = 5;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_REMOVE  = 2'd1,
		ACT_LIST_FW = 2'd2,
		ACT_LIST_RV = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_ITEM     = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    scan_rd;
		logic    shift_init;
		logic    shift_rd;
		logic    list_init;
		logic    list_fwd;
		logic    list_rd;
		logic    emit;
		status_t emit_code;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    mem_wr_ins;
	} uvol_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;
		logic full;
		logic hit;
		logic miss;
		logic shift_done;
		logic list_done;
	} uvol_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/uvol_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvol_dpath
// Value store, scan/shift/list address walker, compare and result registers.
// The list is held back to front: the front entry sits at address count-1.
// ----------------------------------------------------------------------------
module uvol_dpath
	import uvol_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire uvol_cmd_t                 cmd,
	output uvol_stat_t                     stat,
	input  wire logic signed [VALUE_W-1:0] item_value,
	output logic                           strobe,
	output logic [2:0]                     status,
	output logic signed [VALUE_W-1:0]      out_value,
	output logic [COUNT_OUT_W-1:0]         stored_count,
	output logic                           last_of_run
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RW = $clog2(MAX_RESULTS + 1);
	localparam int LW = (CW > RW) ? CW : RW;

	logic [VALUE_W-1:0]        mem [CAPACITY];
	logic [VALUE_W-1:0]        rdata_s1;
	logic [VALUE_W-1:0]        val_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_nxt;
	logic [CW-1:0]             ptr_q;
	logic [CW-1:0]             addr_s1;
	logic [RW-1:0]             rem_q;
	logic                      fwd_q;
	logic                      cmp_v_s1;
	logic                      mov_v_s1;
	logic                      lst_v_s1;
	logic                      lst_last_s1;
	logic                      in_range;
	logic                      scan_go;
	logic                      shift_go;
	logic                      list_go;
	logic                      rd_en;
	logic [LW-1:0]             cnt_w;
	logic [LW-1:0]             run_len;
	logic                      strobe_q;
	status_t                   status_q;
	logic [VALUE_W-1:0]        out_value_q;
	logic [COUNT_OUT_W-1:0]    stored_count_q;
	logic                      last_q;

	assign in_range = (ptr_q < count_q);
	assign scan_go  = cmd.scan_rd && in_range;
	assign shift_go = cmd.shift_rd && in_range;
	assign list_go  = cmd.list_rd && (rem_q != '0);
	assign rd_en    = scan_go || shift_go || list_go;

	assign cnt_w   = LW'(count_q);
	assign run_len = (cnt_w > LW'(MAX_RESULTS)) ? LW'(MAX_RESULTS) : cnt_w;

	always_comb begin
		count_nxt = count_q;
		if (cmd.cnt_inc) begin
			count_nxt = count_q + 1'b1;
		end else if (cmd.cnt_dec) begin
			count_nxt = count_q - 1'b1;
		end
	end

	assign stat.cnt_zero   = (count_q == '0);
	assign stat.full       = (count_q == CW'(CAPACITY));
	assign stat.hit        = cmp_v_s1 && (rdata_s1 == val_q);
	assign stat.miss       = !cmp_v_s1 && !in_range;
	assign stat.shift_done = !mov_v_s1 && !in_range;
	assign stat.list_done  = !lst_v_s1 && (rem_q == '0);

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.mem_wr_ins) begin
			mem[count_q[AW-1:0]] <= val_q;
		end else if (mov_v_s1) begin
			mem[AW'(addr_s1 - 1'b1)] <= rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[ptr_q[AW-1:0]];
			addr_s1  <= ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			fwd_q       <= 1'b0;
			cmp_v_s1    <= 1'b0;
			mov_v_s1    <= 1'b0;
			lst_v_s1    <= 1'b0;
			lst_last_s1 <= 1'b0;
		end else begin
			count_q     <= count_nxt;
			cmp_v_s1    <= scan_go;
			mov_v_s1    <= shift_go;
			lst_v_s1    <= list_go;
			lst_last_s1 <= (rem_q == RW'(1));
			if (cmd.list_init) begin
				// forward listing starts at the front, which is the top address
				ptr_q <= cmd.list_fwd ? count_q - 1'b1 : '0;
				rem_q <= RW'(run_len);
				fwd_q <= cmd.list_fwd;
			end else if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.shift_init) begin
				ptr_q <= addr_s1 + 1'b1;
			end else if (list_go) begin
				ptr_q <= fwd_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
				rem_q <= rem_q - 1'b1;
			end else if (scan_go || shift_go) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= lst_v_s1 || cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (lst_v_s1) begin
			status_q       <= ST_ITEM;
			out_value_q    <= rdata_s1;
			stored_count_q <= COUNT_OUT_W'(count_q);
			last_q         <= lst_last_s1;
		end else if (cmd.emit) begin
			status_q       <= cmd.emit_code;
			out_value_q    <= (cmd.emit_code == ST_EMPTY) ? '0 : val_q;
			stored_count_q <= COUNT_OUT_W'(count_nxt);
			last_q         <= 1'b1;
		end
	end

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign out_value    = out_value_q;
	assign stored_count = stored_count_q;
	assign last_of_run  = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_pipe_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmp_v_s1, mov_v_s1, lst_v_s1}))
		else $error("more than one read kind in flight");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr_ins |-> (count_q < CW'(CAPACITY) && !cmd.cnt_dec))
		else $error("insert write with no room");

	a_list_last: assert property (@(posedge clk) disable iff (!arst_n)
		(lst_v_s1 && lst_last_s1) |=> (strobe_q && last_q))
		else $error("final listed word not marked");

endmodule
`default_nettype wire

// File: rtl/core/uvol_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvol_ctrl
// Sequencer for insert, remove and listing: search, close the gap, walk.
// ----------------------------------------------------------------------------
module uvol_ctrl
	import uvol_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] action,
	output logic            busy,
	output uvol_cmd_t       cmd,
	input  wire uvol_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_LIST   = 4'b1000
	} state_t;

	state_t  state_q;
	state_t  state_nxt;
	action_t act_q;
	action_t act_in;

	assign act_in = action_t'(action);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.emit_code = ST_DONE;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (act_in == ACT_INSERT || act_in == ACT_REMOVE) begin
						state_nxt = S_SEARCH;
					end else if (stat.cnt_zero) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = ST_EMPTY;
					end else begin
						cmd.list_init = 1'b1;
						cmd.list_fwd  = (act_in == ACT_LIST_FW);
						state_nxt     = S_LIST;
					end
				end
			end
			S_SEARCH: begin
				cmd.scan_rd = !stat.hit && !stat.miss;
				if (stat.hit) begin
					if (act_q == ACT_INSERT) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = ST_DUP;
						state_nxt     = S_IDLE;
					end else begin
						cmd.shift_init = 1'b1;
						state_nxt      = S_SHIFT;
					end
				end else if (stat.miss) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
					if (act_q != ACT_INSERT) begin
						cmd.emit_code = ST_NOTFOUND;
					end else if (stat.full) begin
						cmd.emit_code = ST_FULL;
					end else begin
						cmd.mem_wr_ins = 1'b1;
						cmd.cnt_inc    = 1'b1;
					end
				end
			end
			S_SHIFT: begin
				cmd.shift_rd = !stat.shift_done;
				if (stat.shift_done) begin
					cmd.cnt_dec = 1'b1;
					cmd.emit    = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			S_LIST: begin
				cmd.list_rd = 1'b1;
				if (stat.list_done) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= ACT_INSERT;
		end else begin
			state_q <= state_nxt;
			if (start && !busy) begin
				act_q <= act_in;
			end
		end
	end

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && state_q != S_IDLE) |=> !busy)
		else $error("result issued without ending the operation");

	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.scan_rd, cmd.shift_rd, cmd.list_rd, cmd.emit}))
		else $error("conflicting datapath commands");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && cmd.cnt_dec))
		else $error("count raised and lowered together");

endmodule
`default_nettype wire

// File: rtl/core/unique_value_ordered_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unique_value_ordered_list
// Ordered list of distinct signed 32-bit values with insert, remove and listing.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; one operation runs
// at a time. Results appear for one cycle with strobe high and cannot be held
// off, so the receiver must take every word as it comes. Insert makes a linear
// search over the value store, one entry a cycle, to its result; remove
// searches the same way, then moves one entry a cycle to close the gap; and
// a listing gives one word per cycle, at most MAX_RESULTS words. After an
// insert or remove, busy drops in the cycle the result word is on the ports;
// after a listing it drops in the cycle after the final word.
// ----------------------------------------------------------------------------
module unique_value_ordered_list
	import uvol_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                action,
	input  wire logic signed [VALUE_W-1:0] item_value,
	output logic                           strobe,
	output logic [2:0]                     status,
	output logic signed [VALUE_W-1:0]      out_value,
	output logic [COUNT_OUT_W-1:0]         stored_count,
	output logic                           last_of_run
);

	uvol_cmd_t  cmd;
	uvol_stat_t stat;

	uvol_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	uvol_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item_value   (item_value),
		.strobe       (strobe),
		.status       (status),
		.out_value    (out_value),
		.stored_count (stored_count),
		.last_of_run  (last_of_run)
	);

endmodule
`default_nettype wire

// File: tb/unique_value_ordered_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_ordered_list_tb
// Self-checking bench for the unique value ordered list. A queue of commands
// (a directed opening, then random fill, drain and mixed episodes over small
// value pools) feeds a clocked driver. A mirror of the list predicts every
// result word, and a clocked monitor compares each strobed word field by field.
// ----------------------------------------------------------------------------
module unique_value_ordered_list_tb;
	import uvol_pkg::*;

	typedef struct {
		action_t                     act;
		logic signed [VALUE_W-1:0]   value;
		bit                          drain_first;
	} command_t;

	typedef struct {
		status_t                     status;
		logic signed [VALUE_W-1:0]   value;
		logic [COUNT_OUT_W-1:0]      count;
		logic                        last;
	} list_word_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

	localparam int RANDOM_ITEMS = 430;
	localparam int POOL_SIZE    = 24;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	action_t                     action = ACT_INSERT;
	logic signed [VALUE_W-1:0]   item_value = '0;
	logic                        busy;
	logic                        strobe;
	logic [2:0]                  status;
	logic signed [VALUE_W-1:0]   out_value;
	logic [COUNT_OUT_W-1:0]      stored_count;
	logic                        last_of_run;

	command_t                    pending_cmds[$];
	list_word_t                  expected_words[$];
	logic signed [VALUE_W-1:0]   list_mirror[$];
	int                          sent_count = 0;
	int                          error_count = 0;

	unique_value_ordered_list dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.item_value   (item_value),
		.strobe       (strobe),
		.status       (status),
		.out_value    (out_value),
		.stored_count (stored_count),
		.last_of_run  (last_of_run)
	);

	always #1 clk = ~clk;

	// Apply one command to the mirror and queue the words it must produce.
	task automatic predict_command(input action_t act, input logic signed [VALUE_W-1:0] val);
		int         pos;
		int         n;
		int         idx;
		list_word_t w;
		pos = -1;
		foreach (list_mirror[i])
			if (pos < 0 && list_mirror[i] == val)
				pos = i;
		w.value = val;
		w.last  = 1'b1;
		case (act)
			ACT_INSERT: begin
				if (pos >= 0)
					w.status = ST_DUP;
				else if (list_mirror.size() >= CAPACITY_DEF)
					w.status = ST_FULL;
				else begin
					w.status = ST_DONE;
					list_mirror.push_front(val);
				end
				w.count = COUNT_OUT_W'(list_mirror.size());
				expected_words.push_back(w);
			end
			ACT_REMOVE: begin
				if (pos < 0)
					w.status = ST_NOTFOUND;
				else begin
					w.status = ST_DONE;
					list_mirror.delete(pos);
				end
				w.count = COUNT_OUT_W'(list_mirror.size());
				expected_words.push_back(w);
			end
			default: begin
				if (list_mirror.size() == 0) begin
					w.status = ST_EMPTY;
					w.value  = '0;
					w.count  = '0;
					expected_words.push_back(w);
				end else begin
					n = list_mirror.size();
					if (n > MAX_RESULTS)
						n = MAX_RESULTS;
					for (int k = 0; k < n; k++) begin
						idx = (act == ACT_LIST_FW) ? k : list_mirror.size() - 1 - k;
						w.status = ST_ITEM;
						w.value  = list_mirror[idx];
						w.count  = COUNT_OUT_W'(list_mirror.size());
						w.last   = (k + 1 == n);
						expected_words.push_back(w);
					end
				end
			end
		endcase
	endtask

	task automatic queue_command(input action_t act, input logic signed [VALUE_W-1:0] val,
			input bit drain_first);
		command_t c;
		c.act         = act;
		c.value       = val;
		c.drain_first = drain_first;
		pending_cmds.push_back(c);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit       take_next;
		bit       idle_now;
		command_t c;
		if (!arst_n) begin
			start      <= 1'b0;
			action     <= ACT_INSERT;
			item_value <= '0;
		end else begin
			take_next = !start;
			if (start && !busy) begin
				predict_command(action, item_value);
				sent_count = sent_count + 1;
				take_next = 1'b1;
			end
			if (take_next) begin
				// no idling over a long middle stretch
				idle_now = (sent_count < 200 || sent_count >= 320) && ($urandom_range(99) < 8);
				if (pending_cmds.size() != 0 && !idle_now &&
						!(pending_cmds[0].drain_first && expected_words.size() != 0)) begin
					c = pending_cmds.pop_front();
					start      <= 1'b1;
					action     <= c.act;
					item_value <= c.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		list_word_t w;
		if (arst_n && strobe) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word: status %0d value %0d count %0d last %0b",
					$time, status, out_value, stored_count, last_of_run);
				error_count = error_count + 1;
			end else begin
				w = expected_words.pop_front();
				if (status !== w.status) begin
					$display("%0t: status expected %0d actual %0d", $time, w.status, status);
					error_count = error_count + 1;
				end
				if (out_value !== w.value) begin
					$display("%0t: out_value expected %0d actual %0d", $time, w.value, out_value);
					error_count = error_count + 1;
				end
				if (stored_count !== w.count) begin
					$display("%0t: stored_count expected %0d actual %0d", $time, w.count,
						stored_count);
					error_count = error_count + 1;
				end
				if (last_of_run !== w.last) begin
					$display("%0t: last_of_run expected %0b actual %0b", $time, w.last,
						last_of_run);
					error_count = error_count + 1;
				end
			end
		end
	end

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic signed [VALUE_W-1:0] pool[POOL_SIZE];
		mix_t                      mix;
		int                        made;
		int                        span;
		int                        r;
		int                        ins_lim;
		int                        rem_lim;
		action_t                   act;
		logic signed [VALUE_W-1:0] val;

		// directed opening: empty list, extremes, duplicate, remove front/middle/end
		queue_command(ACT_LIST_FW, 32'sd7, 1'b0);
		queue_command(ACT_LIST_RV, -32'sd7, 1'b0);
		queue_command(ACT_REMOVE, 32'sd5, 1'b0);
		queue_command(ACT_INSERT, 32'sh8000_0000, 1'b0);
		queue_command(ACT_INSERT, 32'sh7FFF_FFFF, 1'b0);
		queue_command(ACT_INSERT, 32'sd0, 1'b0);
		queue_command(ACT_INSERT, -32'sd1, 1'b0);
		queue_command(ACT_INSERT, 32'sh7FFF_FFFF, 1'b0);
		queue_command(ACT_LIST_FW, 32'sd0, 1'b1);
		queue_command(ACT_LIST_RV, 32'sd0, 1'b0);
		queue_command(ACT_REMOVE, 32'sd0, 1'b0);
		queue_command(ACT_REMOVE, -32'sd1, 1'b0);
		queue_command(ACT_REMOVE, 32'sh8000_0000, 1'b0);
		queue_command(ACT_REMOVE, 32'sd1234, 1'b0);
		queue_command(ACT_LIST_FW, 32'sd0, 1'b0);
		queue_command(ACT_REMOVE, 32'sh7FFF_FFFF, 1'b0);
		queue_command(ACT_LIST_RV, 32'sd0, 1'b0);

		// random episodes over a small pool so duplicates, hits and full occur
		made = 0;
		while (made < RANDOM_ITEMS) begin
			mix  = (made == 0) ? MIX_FILL : mix_t'($urandom_range(2));
			span = (made == 0) ? 60 : $urandom_range(20, 60);
			foreach (pool[i]) begin
				pool[i] = $urandom;
				if ($urandom_range(9) == 0)
					pool[i] = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end
			case (mix)
				MIX_FILL:  begin ins_lim = 75; rem_lim = 85; end
				MIX_DRAIN: begin ins_lim = 20; rem_lim = 80; end
				default:   begin ins_lim = 45; rem_lim = 75; end
			endcase
			for (int j = 0; j < span && made < RANDOM_ITEMS; j++) begin
				r = $urandom_range(99);
				if (r < ins_lim)
					act = ACT_INSERT;
				else if (r < rem_lim)
					act = ACT_REMOVE;
				else
					act = $urandom_range(1) ? ACT_LIST_FW : ACT_LIST_RV;
				val = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(POOL_SIZE - 1)];
				queue_command(act, val, $urandom_range(49) == 0);
				made++;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		// hold on to catch stray words
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: unique_value_ordered_list.f
rtl/core/uvol_pkg.sv
rtl/core/uvol_dpath.sv
rtl/core/uvol_ctrl.sv
rtl/core/unique_value_ordered_list.sv
tb/unique_value_ordered_list_tb.sv
